// ===== design/bpti_pkg.sv =====
// Shared types, constants and arithmetic helpers for the barycentric
// point-in-triangle interpolator. No dependencies.
package bpti_pkg;

  localparam int MAX_TRIANGLES = 256;
  localparam int CORNER_DEPTH  = 3 * MAX_TRIANGLES;
  localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
  localparam int TRI_W   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CA_W    = $clog2(CORNER_DEPTH);
  localparam int NUM_AXIS = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CW_W    = 224;   // x, y, tex_s, tex_t, orig_s, orig_t, color
  localparam int RECIP_W = 33;
  localparam int SH_W    = 6;
  localparam int INV_W   = RECIP_W + SH_W + 1;
  localparam int IN_W    = 256;
  localparam int OUT_W   = 160;

  localparam logic signed [41:0] EPS_Q30    = 42'sd128;
  localparam logic signed [42:0] INSIDE_MAX = 43'sd1073741952;
  localparam logic [40:0]        WEIGHT_LIMIT = 41'h100_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 3'd5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_SKIP  = 2'd3
  } in_op_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_TAKE, DP_PROJ, DP_PWR, DP_READ, DP_EDGE, DP_AREA0, DP_AREA1,
    DP_NORM, DP_DIV, DP_INVWR, DP_QMUL, DP_WT, DP_LERP, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [5:0]        idx;
    logic [CA_W-1:0]   addr;
    logic [TRI_W-1:0]  tri_idx;
    logic              hit;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic area_zero;
    logic in_tri;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [31:0] satsym(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sd2147483647) return 32'sh7fffffff;
    else if (d < -33'sd2147483647) return 32'sh80000001;
    else return d[31:0];
  endfunction

  function automatic logic signed [31:0] proj_round(input logic signed [49:0] acc);
    logic signed [49:0] r;
    r = (acc + 50'sd8192) >>> 14;
    return sat32(64'(r));
  endfunction

endpackage

// ===== design/barycentric_point_triangle_interp.sv =====
// Top level of the barycentric point-in-triangle interpolator.
// Depends on bpti_pkg, bpti_ctrl and bpti_datapath.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  s_tuser op, s_tdata corner or query
//   m_*      out        m_tvalid / m_tready  m_tuser hit, m_tdata interpolation
//   cfg_*    in         cfg_wr_en            cfg_addr index, cfg_wr_data axis
//
// Clear and skip items end in idle. A corner load projects the item and writes
// it; the third corner adds triangle setup: edges, area, a normalize and a
// reciprocal division. A query walks the stored triangles, interpolating on a
// hit; the walk reads three corners per triangle through one memory port.
// Reset is synchronous and empties the table; memories are not cleared.
// A finished result waits in the output register while the next item enters.
module barycentric_point_triangle_interp import bpti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // pos_x, pos_y, pos_z, tex_s, tex_t,
                                          // orig_s, orig_t, corner_color
  input  logic [1:0]           s_tuser,   // op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // out_tex_s, out_tex_t, out_orig_s,
                                          // out_orig_t, out_color
  output logic                 m_tuser,   // hit
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (in_op_t'(s_tuser)),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bpti_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (m_tdata),
    .out_hit     (m_tuser)
  );

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == DP_OUT))
    else $error("result shown without a load of the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_OUT |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a result waits");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tdata == '0)
    else $error("miss result carries nonzero data");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (cmd.op == DP_TAKE || cmd.op == DP_NOP))
    else $error("datapath busy while input is accepted");

endmodule

// ===== design/bpti_datapath.sv =====
// Datapath: axis registers, corner and inverse memories, shared multipliers,
// reciprocal divider and interpolation arithmetic. Depends on bpti_pkg.
module bpti_datapath import bpti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic [IN_W-1:0]       in_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_hit
);

  logic signed [15:0] axis [NUM_AXIS];
  logic [IN_W-1:0]    item;
  logic signed [31:0] pos_x, pos_y, pos_z, pos_sel;
  logic signed [15:0] ax_sel;
  logic signed [47:0] pprod;
  logic signed [49:0] acc;
  logic signed [31:0] left_q;

  logic [CW_W-1:0]  corner_mem [CORNER_DEPTH];
  logic [CW_W-1:0]  rd_q;
  logic [CW_W-1:0]  cw [3];
  logic [INV_W-1:0] inv_mem [MAX_TRIANGLES];
  logic [INV_W-1:0] inv_q;
  logic               inv_neg;
  logic [SH_W-1:0]    inv_sh;
  logic [RECIP_W-1:0] inv_recip;

  logic signed [31:0] e0, e1, e2, e3, dx, dy, ma, mb;
  logic signed [63:0] mprod, pmul, mdiff, nu, nv;
  logic               area_neg, area_zero;
  logic [62:0]        mnorm;
  logic [SH_W-1:0]    sh;
  logic [31:0]        rem;
  logic [RECIP_W-1:0] quo;
  logic [32:0]        rem_sh, dvs;

  logic signed [63:0] num;
  logic [63:0]        nmag;
  logic [31:0]        wa;
  logic [64:0]        wprod;
  logic [63:0]        lo, hi;
  logic [95:0]        wfull, wshift;
  logic [6:0]         wsh;
  logic [40:0]        wres;
  logic               wneg;
  logic signed [41:0] wval, u, v;
  logic signed [42:0] usum;

  logic [1:0]         fsel, ch;
  logic signed [31:0] a0, a1, a2, uw, vw, lw;
  logic signed [32:0] d1, d2, ld;
  logic signed [64:0] lp, lr;
  logic signed [34:0] lr35, t1;
  logic signed [31:0] res_f [4];
  logic [31:0]        res_color;
  logic [7:0]         c0, c1, c2;
  logic signed [33:0] w0;
  logic signed [31:0] w0_32;
  logic signed [43:0] csum, cr;
  logic [7:0]         cclamp;

  assign pos_x = item[31:0];
  assign pos_y = item[63:32];
  assign pos_z = item[95:64];

  // projection: one axis component per cycle
  always_comb begin
    case (cmd.idx)
      6'd0, 6'd3: pos_sel = pos_x;
      6'd1, 6'd4: pos_sel = pos_y;
      default:    pos_sel = pos_z;
    endcase
    ax_sel = axis[cmd.idx[2:0]];
    pprod  = pos_sel * ax_sel;
  end

  // shared 32x32 multiplier for area and numerators
  always_comb begin
    ma = e0;
    mb = e3;
    case (cmd.op)
      DP_AREA1: begin
        ma = e1; mb = e2;
      end
      DP_QMUL: begin
        case (cmd.idx[1:0])
          2'd0:    begin ma = dx; mb = e3; end
          2'd1:    begin ma = dy; mb = e2; end
          2'd2:    begin ma = e0; mb = dy; end
          default: begin ma = e1; mb = dx; end
        endcase
      end
      default: ;
    endcase
    mprod = ma * mb;
    mdiff = pmul - mprod;
  end

  assign rem_sh = {rem, (cmd.idx == 6'd0)};
  assign dvs    = {1'b0, mnorm[62:31]};

  // weight = min((|num| * recip) >> (64 - sh), 2^40), signed
  always_comb begin
    num   = (cmd.idx >= 6'd3) ? nv : nu;
    nmag  = num[63] ? (~num + 64'd1) : num;
    wa    = (cmd.idx == 6'd0 || cmd.idx == 6'd3) ? nmag[31:0] : nmag[63:32];
    wprod = 65'(wa) * 65'(inv_recip);
    wfull = {hi, lo[31:0]};
    wsh   = 7'd64 - {1'b0, inv_sh};
    wshift = wfull >> wsh;
    wres  = (wshift > 96'(WEIGHT_LIMIT)) ? WEIGHT_LIMIT : wshift[40:0];
    wneg  = num[63] ^ inv_neg;
    wval  = wneg ? -$signed({1'b0, wres}) : $signed({1'b0, wres});
    usum  = 43'(u) + 43'(v);
  end

  assign stat.in_tri    = !(u < -EPS_Q30 || v < -EPS_Q30 || usum > INSIDE_MAX);
  assign stat.area_zero = area_zero;
  assign stat.norm_done = mnorm[62];

  // interpolation operands
  always_comb begin
    fsel = cmd.idx[2:1];
    ch   = cmd.idx[1:0];
    a0 = cw[0][(64 + 32 * fsel) +: 32];
    a1 = cw[1][(64 + 32 * fsel) +: 32];
    a2 = cw[2][(64 + 32 * fsel) +: 32];
    uw = u[31:0];
    vw = v[31:0];
    d1 = 33'(a1) - 33'(a0);
    d2 = 33'(a2) - 33'(a0);
    ld = cmd.idx[0] ? d2 : d1;
    lw = cmd.idx[0] ? vw : uw;
    lp = 65'(ld) * 65'(lw);
    lr = (lp + 65'sd536870912) >>> 30;
    lr35 = lr[34:0];
    c0 = cw[0][(192 + 8 * ch) +: 8];
    c1 = cw[1][(192 + 8 * ch) +: 8];
    c2 = cw[2][(192 + 8 * ch) +: 8];
    w0 = 34'sd1073741824 - 34'(uw) - 34'(vw);
    w0_32 = w0[31:0];
    csum = 44'($signed({1'b0, c0})) * 44'(w0_32)
         + 44'($signed({1'b0, c1})) * 44'(uw)
         + 44'($signed({1'b0, c2})) * 44'(vw);
    cr = (csum + 44'sd536870912) >>> 30;
    if (cr < 44'sd0) cclamp = 8'd0;
    else if (cr > 44'sd255) cclamp = 8'd255;
    else cclamp = cr[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXIS; i++) axis[i] <= '0;
      axis[CFG_LEFT_X] <= 16'sd16384;
      axis[CFG_DOWN_Y] <= 16'sd16384;
    end else if (cfg_wr_en && cfg_addr <= CFG_LAST) begin
      axis[cfg_addr] <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q  <= corner_mem[cmd.addr];
    inv_q <= inv_mem[cmd.tri_idx];
    if (cmd.op == DP_PWR) begin
      corner_mem[cmd.addr] <= {item[255:96], proj_round(acc), left_q};
    end
    if (cmd.op == DP_INVWR) begin
      inv_mem[cmd.tri_idx] <= {quo, sh, area_neg};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_TAKE: item <= in_data;
      DP_PROJ: begin
        acc <= ((cmd.idx == 6'd0 || cmd.idx == 6'd3) ? 50'sd0 : acc) + 50'(pprod);
        if (cmd.idx == 6'd3) left_q <= proj_round(acc);
      end
      DP_READ: begin
        if (cmd.idx != 6'd0) cw[cmd.idx[1:0] - 2'd1] <= rd_q;
        if (cmd.idx == 6'd1) begin
          {inv_recip, inv_sh, inv_neg} <= inv_q;
        end
      end
      DP_EDGE: begin
        e0 <= satsym(cw[1][31:0], cw[0][31:0]);
        e1 <= satsym(cw[1][63:32], cw[0][63:32]);
        e2 <= satsym(cw[2][31:0], cw[0][31:0]);
        e3 <= satsym(cw[2][63:32], cw[0][63:32]);
        dx <= satsym(pos_x, cw[0][31:0]);
        dy <= satsym(pos_y, cw[0][63:32]);
      end
      DP_AREA0: pmul <= mprod;
      DP_AREA1: begin
        area_neg  <= mdiff[63];
        area_zero <= (mdiff == 64'sd0);
        mnorm     <= mdiff[63] ? 63'(-mdiff) : mdiff[62:0];
        sh        <= '0;
        rem       <= '0;
        quo       <= '0;
      end
      DP_NORM: begin
        if (!mnorm[62]) begin
          mnorm <= {mnorm[61:0], 1'b0};
          sh    <= sh + 6'd1;
        end
      end
      DP_DIV: begin
        if (rem_sh >= dvs) begin
          rem <= 32'(rem_sh - dvs);
          quo <= {quo[RECIP_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quo <= {quo[RECIP_W-2:0], 1'b0};
        end
      end
      DP_QMUL: begin
        case (cmd.idx[1:0])
          2'd1:    nu <= mdiff;
          2'd3:    nv <= mdiff;
          default: pmul <= mprod;
        endcase
      end
      DP_WT: begin
        case (cmd.idx)
          6'd0, 6'd3: lo <= wprod[63:0];
          6'd1, 6'd4: hi <= wprod[63:0] + {32'd0, lo[63:32]};
          6'd2:       u <= wval;
          default:    v <= wval;
        endcase
      end
      DP_LERP: begin
        if (cmd.idx >= 6'd8) begin
          res_color[8 * ch +: 8] <= cclamp;
        end else if (!cmd.idx[0]) begin
          t1 <= lr35;
        end else begin
          res_f[fsel] <= sat32(64'(a0) + 64'(t1) + 64'(lr35));
        end
      end
      DP_OUT: begin
        out_hit  <= cmd.hit;
        out_data <= cmd.hit ? {res_color, res_f[3], res_f[2], res_f[1], res_f[0]} : '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/bpti_ctrl.sv =====
// Controller: sequences corner loads, triangle setup and the query walk,
// and owns the table bookkeeping and the output valid. Depends on bpti_pkg.
module bpti_ctrl import bpti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_op_t   in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_PROJ  = 17'h00002,
    ST_PWR   = 17'h00004,
    ST_TRD   = 17'h00008,
    ST_TEDGE = 17'h00010,
    ST_AREA0 = 17'h00020,
    ST_AREA1 = 17'h00040,
    ST_NORM  = 17'h00080,
    ST_DIV   = 17'h00100,
    ST_INVWR = 17'h00200,
    ST_QRD   = 17'h00400,
    ST_QEDGE = 17'h00800,
    ST_QMUL  = 17'h01000,
    ST_WT    = 17'h02000,
    ST_TEST  = 17'h04000,
    ST_LERP  = 17'h08000,
    ST_QOUT  = 17'h10000
  } state_t;

  state_t           state, state_next;
  logic [5:0]       cnt, cnt_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       phase, phase_next;
  logic [TRI_W-1:0] tix, tix_next;
  logic [CA_W-1:0]  base, base_next, count3;
  logic             hit_q, hit_next, valid_next;

  assign in_ready = (state == ST_IDLE);
  assign count3   = CA_W'({count, 1'b0}) + CA_W'(count);

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 6'd1;
    count_next = count;
    phase_next = phase;
    tix_next   = tix;
    base_next  = base;
    hit_next   = hit_q;
    valid_next = out_valid && !out_ready;
    cmd.op      = DP_NOP;
    cmd.idx     = cnt;
    cmd.addr    = base + CA_W'(cnt[1:0]);
    cmd.tri_idx = tix;
    cmd.hit     = hit_q;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.op = DP_TAKE;
          case (in_op)
            OP_CLEAR: begin
              count_next = '0;
              phase_next = '0;
            end
            OP_LOAD: begin
              if (count < CNT_W'(MAX_TRIANGLES)) begin
                base_next  = count3;
                state_next = ST_PROJ;
              end else begin
                phase_next = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
              end
            end
            OP_QUERY: begin
              tix_next   = '0;
              base_next  = '0;
              hit_next   = 1'b0;
              state_next = (count == '0) ? ST_QOUT : ST_QRD;
            end
            default: ;
          endcase
        end
      end
      ST_PROJ: begin
        cmd.op = DP_PROJ;
        if (cnt == 6'd5) state_next = ST_PWR;
      end
      ST_PWR: begin
        cmd.op   = DP_PWR;
        cmd.addr = base + CA_W'(phase);
        cnt_next = '0;
        if (phase == 2'd2) begin
          state_next = ST_TRD;
        end else begin
          phase_next = phase + 2'd1;
          state_next = ST_IDLE;
        end
      end
      ST_TRD: begin
        cmd.op = DP_READ;
        if (cnt == 6'd3) state_next = ST_TEDGE;
      end
      ST_TEDGE: begin
        cmd.op = DP_EDGE;
        state_next = ST_AREA0;
      end
      ST_AREA0: begin
        cmd.op = DP_AREA0;
        state_next = ST_AREA1;
      end
      ST_AREA1: begin
        cmd.op = DP_AREA1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.op   = DP_NORM;
        cnt_next = '0;
        if (stat.area_zero) begin
          // degenerate: drop the triangle
          phase_next = '0;
          state_next = ST_IDLE;
        end else if (stat.norm_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = DP_DIV;
        if (cnt == 6'd63) state_next = ST_INVWR;
      end
      ST_INVWR: begin
        cmd.op      = DP_INVWR;
        cmd.tri_idx = count[TRI_W-1:0];
        count_next  = count + CNT_W'(1);
        phase_next  = '0;
        state_next  = ST_IDLE;
      end
      ST_QRD: begin
        cmd.op = DP_READ;
        if (cnt == 6'd3) begin
          cnt_next   = '0;
          state_next = ST_QEDGE;
        end
      end
      ST_QEDGE: begin
        cmd.op     = DP_EDGE;
        cnt_next   = '0;
        state_next = ST_QMUL;
      end
      ST_QMUL: begin
        cmd.op = DP_QMUL;
        if (cnt == 6'd3) begin
          cnt_next   = '0;
          state_next = ST_WT;
        end
      end
      ST_WT: begin
        cmd.op = DP_WT;
        if (cnt == 6'd5) state_next = ST_TEST;
      end
      ST_TEST: begin
        cnt_next = '0;
        if (stat.in_tri) begin
          hit_next   = 1'b1;
          state_next = ST_LERP;
        end else if (CNT_W'(tix) + CNT_W'(1) < count) begin
          // advance to the next stored triangle
          tix_next   = tix + TRI_W'(1);
          base_next  = base + CA_W'(3);
          state_next = ST_QRD;
        end else begin
          state_next = ST_QOUT;
        end
      end
      ST_LERP: begin
        cmd.op = DP_LERP;
        if (cnt == 6'd11) state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = DP_OUT;
          valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      count     <= '0;
      phase     <= '0;
      tix       <= '0;
      base      <= '0;
      hit_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      count     <= count_next;
      phase     <= phase_next;
      tix       <= tix_next;
      base      <= base_next;
      hit_q     <= hit_next;
      out_valid <= valid_next;
    end
  end

endmodule
